// ----- rtl/plist_pkg.sv -----
package plist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int RPOS_W   = 9;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_POS  = 3'd0,
    MODE_INS_END  = 3'd1,
    MODE_DEL_POS  = 3'd2,
    MODE_DEL_END  = 3'd3,
    MODE_SEARCH   = 3'd4,
    MODE_TRAVERSE = 3'd5
  } plist_mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } plist_status_e;

  typedef struct packed {
    plist_status_e            status;
    logic signed [VAL_W-1:0]  value;
    logic [RPOS_W-1:0]        position;
    logic                     last;
  } plist_res_t;

endpackage

// ----- rtl/plist_ram.sv -----
module plist_ram
  import plist_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic signed [VAL_W-1:0] rdata_o
);

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/plist_ctrl.sv -----
module plist_ctrl
  import plist_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    op_valid_i,
  output logic                    op_ready_o,
  input  logic [MODE_W-1:0]       op_mode_i,
  input  logic [POS_W-1:0]        op_pos_i,
  input  logic signed [VAL_W-1:0] op_value_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output plist_res_t              res_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_INS      = 12'b0000_0000_0010,
    S_INS_WR   = 12'b0000_0000_0100,
    S_DEL_RD   = 12'b0000_0000_1000,
    S_DEL_CAP  = 12'b0000_0001_0000,
    S_DEL      = 12'b0000_0010_0000,
    S_DEL_WR   = 12'b0000_0100_0000,
    S_SRCH_RD  = 12'b0000_1000_0000,
    S_SRCH_CMP = 12'b0001_0000_0000,
    S_TRV_RD   = 12'b0010_0000_0000,
    S_TRV_CAP  = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [LEN_W-1:0]        ptr_q, ptr_d;
  logic [LEN_W-1:0]        tgt_q, tgt_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic                    trav_q, trav_d;
  plist_res_t              res_q, res_d;

  logic                    we;
  logic [IDX_W-1:0]        waddr, raddr;
  logic signed [VAL_W-1:0] wdata, rdata;
  logic [LEN_W-1:0]        ptr_inc, ptr_dec;
  logic                    pos_gt_len;
  logic [POS_W-1:0]        pos_m1;

  plist_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ptr_inc    = ptr_q + 1'b1;
  assign ptr_dec    = ptr_q - 1'b1;
  assign pos_gt_len = RPOS_W'(op_pos_i) > RPOS_W'(len_q);
  assign pos_m1     = op_pos_i - 1'b1;

  function automatic plist_res_t err_res(plist_status_e st);
    plist_res_t r;
    r.status   = st;
    r.value    = '0;
    r.position = '0;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic plist_res_t ok_res(logic signed [VAL_W-1:0] v,
                                        logic [LEN_W-1:0] p0, logic fin);
    plist_res_t r;
    r.status   = ST_OK;
    r.value    = v;
    r.position = RPOS_W'(p0) + 1'b1;
    r.last     = fin;
    return r;
  endfunction

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    ptr_d      = ptr_q;
    tgt_d      = tgt_q;
    key_d      = key_q;
    trav_d     = trav_q;
    res_d      = res_q;
    we         = 1'b0;
    waddr      = ptr_q[IDX_W-1:0];
    wdata      = rdata;
    raddr      = ptr_q[IDX_W-1:0];
    op_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          key_d  = op_value_i;
          trav_d = 1'b0;
          case (plist_mode_e'(op_mode_i))
            MODE_INS_POS, MODE_INS_END: begin
              if (32'(len_q) >= CAPACITY) begin
                res_d   = err_res(ST_FULL);
                state_d = S_EMIT;
              end else begin
                ptr_d = len_q;
                if (plist_mode_e'(op_mode_i) == MODE_INS_END || pos_gt_len) begin
                  tgt_d = len_q;
                end else if (op_pos_i == '0 || len_q == '0) begin
                  tgt_d = '0;
                end else begin
                  tgt_d = LEN_W'(op_pos_i);
                end
                state_d = S_INS;
              end
            end
            MODE_DEL_POS: begin
              if (len_q == '0) begin
                res_d   = err_res(ST_EMPTY);
                state_d = S_EMIT;
              end else if (op_pos_i == '0) begin
                res_d   = err_res(ST_INVALID);
                state_d = S_EMIT;
              end else if (pos_gt_len) begin
                res_d   = err_res(ST_BEYOND);
                state_d = S_EMIT;
              end else begin
                ptr_d   = LEN_W'(pos_m1);
                tgt_d   = LEN_W'(pos_m1);
                state_d = S_DEL_RD;
              end
            end
            MODE_DEL_END: begin
              if (len_q == '0) begin
                res_d   = err_res(ST_EMPTY);
                state_d = S_EMIT;
              end else begin
                ptr_d   = len_q - 1'b1;
                tgt_d   = len_q - 1'b1;
                state_d = S_DEL_RD;
              end
            end
            MODE_SEARCH: begin
              if (len_q == '0) begin
                res_d   = err_res(ST_EMPTY);
                state_d = S_EMIT;
              end else begin
                ptr_d   = '0;
                state_d = S_SRCH_RD;
              end
            end
            MODE_TRAVERSE: begin
              if (len_q == '0) begin
                res_d   = err_res(ST_EMPTY);
                state_d = S_EMIT;
              end else begin
                ptr_d   = '0;
                trav_d  = 1'b1;
                state_d = S_TRV_RD;
              end
            end
            default: ; // unused codes: dropped silently
          endcase
        end
      end
      S_INS: begin
        if (ptr_q == tgt_q) begin
          we      = 1'b1;
          waddr   = tgt_q[IDX_W-1:0];
          wdata   = key_q;
          len_d   = len_q + 1'b1;
          res_d   = ok_res(key_q, tgt_q, 1'b1);
          state_d = S_EMIT;
        end else begin
          raddr   = ptr_dec[IDX_W-1:0];
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_INS;
      end
      S_DEL_RD: begin
        state_d = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        key_d   = rdata;
        state_d = S_DEL;
      end
      S_DEL: begin
        if (ptr_inc >= len_q) begin
          len_d   = len_q - 1'b1;
          res_d   = ok_res(key_q, tgt_q, 1'b1);
          state_d = S_EMIT;
        end else begin
          raddr   = ptr_inc[IDX_W-1:0];
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        we      = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DEL;
      end
      S_SRCH_RD: begin
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata == key_q) begin
          res_d   = ok_res(key_q, ptr_q, 1'b1);
          state_d = S_EMIT;
        end else if (ptr_inc >= len_q) begin
          res_d   = err_res(ST_NOT_FOUND);
          state_d = S_EMIT;
        end else begin
          ptr_d   = ptr_inc;
          state_d = S_SRCH_RD;
        end
      end
      S_TRV_RD: begin
        state_d = S_TRV_CAP;
      end
      S_TRV_CAP: begin
        res_d   = ok_res(rdata, ptr_q, ptr_inc == len_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          if (trav_q && !res_q.last) begin
            ptr_d   = ptr_inc;
            state_d = S_TRV_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      trav_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      trav_q  <= trav_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tgt_q <= tgt_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values, one operation per input transaction.
//
// Input stream (s_*): tuser carries the mode (insert after position, insert
// at end, delete at position, delete at end, search, traverse); tdata
// carries position and value. Modes 6 and 7 are swallowed with no result.
// Output stream (m_*): one result per operation, except traverse of a
// non-empty list which gives one result per entry; tlast marks the final
// result of an operation, tuser carries the status code.
//
// Sequencing: the list sits in a RAM with registered reads, and one
// sequencer moves entries one at a time, a read step and a write step per
// move. Insert shifts the entries from its slot onward up by one, delete
// first reads the entry it removes and then shifts the rest down, search
// scans from the front, traverse reads one entry per result, and errors and
// full-list inserts go straight to the result. The sequencer returns to idle
// after its last result leaves it; s_tready is high only while it is idle.
// A one-deep output register lets the next operation in while a result
// waits; a stalled receiver holds the sequencer in its emit step.
// Reset (async, active low) empties the list and drops any pending result.
module positional_list_engine
  import plist_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [7:0] position, [39:8] value
  input  logic [2:0]  s_tuser_i,   // [2:0] mode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,   // [31:0] result_value, [40:32] result_position, zero pad
  output logic [2:0]  m_tuser_o,   // [2:0] status
  output logic        m_tlast_o    // last result of the operation
);

  logic       res_valid, res_ready;
  plist_res_t res;

  logic       out_valid_q;
  plist_res_t out_q;

  plist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (s_tvalid_i),
    .op_ready_o  (s_tready_o),
    .op_mode_i   (s_tuser_i),
    .op_pos_i    (s_tdata_i[7:0]),
    .op_value_i  (s_tdata_i[39:8]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or being drained this cycle.
  assign res_ready = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'b0, out_q.position, out_q.value};
  assign m_tuser_o  = out_q.status;
  assign m_tlast_o  = out_q.last;

endmodule

// ----- rtl/plist_checker.sv -----
module plist_checker
  import plist_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic [39:0] s_tdata_i,
  input logic [2:0]  s_tuser_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [47:0] m_tdata_o,
  input logic [2:0]  m_tuser_o,
  input logic        m_tlast_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o)
      && $stable(m_tuser_o) && $stable(m_tlast_o))
    else $error("stalled output transaction changed");

  // an accepted operation in a defined mode takes the sequencer out of idle, so s_tready drops
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i <= MODE_TRAVERSE) |=> !s_tready_o)
    else $error("input taken on the cycle after an operation");

  // error results carry zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o != ST_OK) |-> (m_tdata_o == '0))
    else $error("error result with nonzero payload");

  // an error always ends the operation
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o != ST_OK) |-> m_tlast_o)
    else $error("error result without tlast");

  // good results report a position from 1 to CAPACITY
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == ST_OK) |->
      (m_tdata_o[40:32] != '0) && (32'(m_tdata_o[40:32]) <= CAPACITY))
    else $error("result position out of range");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import plist_pkg::*;

  // Modes outside the enum: the engine swallows them with no result
  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

  localparam int RANDOM_OPS = 400;
  localparam int STEADY_OPS = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] position, [39:8] value
  logic [2:0]  s_tuser;   // [2:0] mode
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [31:0] result_value, [40:32] result_position, zero pad
  logic [2:0]  m_tuser;   // [2:0] status
  logic        m_tlast;

  positional_list_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  // Shadow copy of the list contents, front at index 0
  logic signed [VAL_W-1:0] shadow_list[$];
  // Results predicted but not yet seen on the output stream, oldest first
  plist_res_t              expected_results[$];
  plist_res_t              oldest_result;

  int  mismatches   = 0;
  int  ops_sent     = 0;
  int  results_seen = 0;
  int  full_rejects = 0;
  int  empty_errors = 0;
  // When set, neither side idles: back-to-back transactions at full rate
  bit  steady       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the engine hangs on either handshake
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Predict the results of one accepted operation and queue them
  function automatic void apply_list_op(input logic [MODE_W-1:0] op,
                                        input logic [POS_W-1:0]  pos,
                                        input logic signed [VAL_W-1:0] val);
    plist_res_t r;
    int         len;
    int         slot;
    len = shadow_list.size();
    r   = '{status: ST_OK, value: '0, position: '0, last: 1'b1};
    case (op)
      MODE_INS_POS, MODE_INS_END: begin
        if (len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // insert after pos: 0 or empty list -> front, past the end -> append
          if (op == MODE_INS_END || pos > len) slot = len;
          else if (pos == 0 || len == 0)      slot = 0;
          else                                slot = pos;
          shadow_list.insert(slot, val);
          r.value    = val;
          r.position = RPOS_W'(slot + 1);
        end
      end
      MODE_DEL_POS: begin
        // empty check wins over the position checks
        if (len == 0)        r.status = ST_EMPTY;
        else if (pos == 0)   r.status = ST_INVALID;
        else if (pos > len)  r.status = ST_BEYOND;
        else begin
          r.value    = shadow_list[pos - 1];
          r.position = RPOS_W'(pos);
          shadow_list.delete(pos - 1);
        end
      end
      MODE_DEL_END: begin
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value    = shadow_list[len - 1];
          r.position = RPOS_W'(len);
          shadow_list.delete(len - 1);
        end
      end
      MODE_SEARCH: begin
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          // first match wins
          for (int i = 0; i < len; i++) begin
            if (r.status == ST_NOT_FOUND && shadow_list[i] == val) begin
              r.status   = ST_OK;
              r.value    = val;
              r.position = RPOS_W'(i + 1);
            end
          end
        end
      end
      MODE_TRAVERSE: begin
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < len; i++) begin
            expected_results.push_back('{status: ST_OK, value: shadow_list[i],
                                         position: RPOS_W'(i + 1),
                                         last: (i == len - 1)});
          end
          return;
        end
      end
      default: return;  // reserved modes: nothing comes out, list untouched
    endcase
    expected_results.push_back(r);
  endfunction

  // Present one operation and hold it until the engine takes it. Valid stays
  // high after acceptance so the next call can follow back to back.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val);
    int g;
    g = steady ? 0 : idle_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, pos};
    do @(posedge clk_i); while (!s_tready);
    apply_list_op(op, pos, val);
    ops_sent++;
  endtask

  // Drop valid and wait for every predicted result to come out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Output side: ready in bursts, broken by random stalls
  initial begin
    int n;
    int g;
    m_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 8);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk_i);
        g = idle_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  end

  // Every result transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d value %0d pos %0d",
                                  m_tuser, $signed(m_tdata[31:0]), m_tdata[40:32]));
      end else begin
        oldest_result = expected_results.pop_front();
        if (m_tuser !== oldest_result.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tuser,
                                    oldest_result.status));
        if (m_tdata[31:0] !== oldest_result.value)
          report_mismatch($sformatf("value %0d, want %0d", $signed(m_tdata[31:0]),
                                    oldest_result.value));
        if (m_tdata[40:32] !== oldest_result.position)
          report_mismatch($sformatf("position %0d, want %0d", m_tdata[40:32],
                                    oldest_result.position));
        if (m_tlast !== oldest_result.last)
          report_mismatch($sformatf("tlast %0b, want %0b", m_tlast,
                                    oldest_result.last));
        if (oldest_result.status == ST_FULL)  full_rejects++;
        if (oldest_result.status == ST_EMPTY) empty_errors++;
      end
    end
  end

  // Values: corners, a small pool that makes duplicates, or anything
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 8) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly positions near the current length, some anywhere in range
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 9) < 7)
      return POS_W'($urandom_range(0, shadow_list.size() + 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Search key: half the time something that is stored
  function automatic logic signed [VAL_W-1:0] pick_key();
    if (shadow_list.size() != 0 && $urandom_range(0, 1))
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_list();
    send_op(MODE_TRAVERSE, 8'd0, 32'sd0);
    send_op(MODE_SEARCH,   8'd0, 32'sd7);
    send_op(MODE_DEL_POS,  8'd0, 32'sd0);   // empty reported before invalid position
    send_op(MODE_DEL_POS,  8'd3, 32'sd0);
    send_op(MODE_DEL_END,  8'd0, 32'sd0);
    send_op(MODE_RSVD_6,   8'hFF, 32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  task automatic test_insert_cases();
    send_op(MODE_INS_POS,  8'd9,   32'h7FFF_FFFF);  // empty list: goes to the front
    send_op(MODE_INS_END,  8'd0,   32'h8000_0000);
    send_op(MODE_INS_POS,  8'd255, 32'sd0);         // past the end: appended
    send_op(MODE_INS_POS,  8'd1,   -32'sd1);        // after the first entry
    send_op(MODE_INS_POS,  8'd0,   32'sd5);         // position zero: front
    send_op(MODE_RSVD_7,   8'hAA,  32'h5555_5555);
    send_op(MODE_TRAVERSE, 8'd0,   32'sd0);
    wait_for_drain();
  endtask

  task automatic test_search_delete();
    send_op(MODE_SEARCH,   8'd0,   -32'sd1);
    send_op(MODE_SEARCH,   8'd0,   32'sd12345);     // miss
    send_op(MODE_INS_END,  8'd0,   -32'sd1);        // duplicate: first one is found
    send_op(MODE_SEARCH,   8'd0,   -32'sd1);
    send_op(MODE_DEL_POS,  8'd0,   32'sd0);         // invalid position
    send_op(MODE_DEL_POS,  8'd200, 32'sd0);         // beyond length
    send_op(MODE_DEL_POS,  8'd2,   32'sd0);
    send_op(MODE_DEL_END,  8'd0,   32'sd0);
    send_op(MODE_TRAVERSE, 8'd0,   32'sd0);
    wait_for_drain();
  endtask

  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY)
      send_op(MODE_INS_END, pick_position(), pick_value());
    send_op(MODE_INS_POS,  8'd3, 32'sd42);          // full: rejected
    send_op(MODE_INS_END,  8'd0, 32'sd43);
    send_op(MODE_TRAVERSE, 8'd0, 32'sd0);           // longest burst of results
    send_op(MODE_DEL_POS,  POS_W'(CAPACITY), 32'sd0); // last slot
    send_op(MODE_DEL_POS,  8'd1, 32'sd0);           // first slot
    wait_for_drain();
  endtask

  // Random operations that swing the list between empty and full so the
  // boundary cases keep coming up with random content.
  task automatic test_random_ops(input int count);
    bit                      growing;
    int                      r;
    int                      len;
    logic [MODE_W-1:0]       op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    growing = 1'b1;
    for (int k = 0; k < count; k++) begin
      len = shadow_list.size();
      if (len == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
      if (len == 0 && $urandom_range(0, 1) == 0)        growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 35)      op = MODE_INS_POS;
        else if (r < 60) op = MODE_INS_END;
        else if (r < 70) op = MODE_DEL_POS;
        else if (r < 75) op = MODE_DEL_END;
        else if (r < 88) op = MODE_SEARCH;
        else if (r < 95) op = MODE_TRAVERSE;
        else             op = r[0] ? MODE_RSVD_6 : MODE_RSVD_7;
      end else begin
        if (r < 10)      op = MODE_INS_POS;
        else if (r < 18) op = MODE_INS_END;
        else if (r < 50) op = MODE_DEL_POS;
        else if (r < 66) op = MODE_DEL_END;
        else if (r < 82) op = MODE_SEARCH;
        else if (r < 95) op = MODE_TRAVERSE;
        else             op = r[0] ? MODE_RSVD_6 : MODE_RSVD_7;
      end
      pos = pick_position();
      val = (op == MODE_SEARCH) ? pick_key() : pick_value();
      send_op(op, pos, val);
    end
    wait_for_drain();
  endtask

  // Same mix with both sides at full rate
  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    test_random_ops(count);
    steady = 1'b0;
  endtask

  initial begin
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_INS_POS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_insert_cases();
    test_search_delete();
    test_full_list();
    test_random_ops(RANDOM_OPS / 2);
    test_back_to_back(STEADY_OPS);
    test_random_ops(RANDOM_OPS / 2);

    // Let anything stray from the reserved modes show up before closing
    repeat (60) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d list operations and %0d checked result transactions,",
             ops_sent, results_seen);
    $display("including %0d full-list rejects and %0d empty-list errors.",
             full_rejects, empty_errors);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/plist_pkg.sv
rtl/plist_ram.sv
rtl/plist_ctrl.sv
rtl/positional_list_engine.sv
rtl/plist_checker.sv
tb/sv/tb.sv
